// ===== sv/assert_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers for the histogram block.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property holds at every rising clock edge outside reset
`define ASSERT_AT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// condition never holds outside reset
`define ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

// ===== sv/bhp_pkg.sv =====
// ---------------------------------------------------------------------------
// bhp_pkg
// Types and constants of the bucket histogram block.
// ---------------------------------------------------------------------------
package bhp_pkg;

  localparam int unsigned LIMIT_REGS = 8;
  localparam int unsigned LIM_IDX_W  = 3;
  localparam int unsigned DATA_W     = 32;
  localparam int unsigned SUM_W      = DATA_W + LIM_IDX_W;
  localparam int unsigned NUM_W      = DATA_W + 7;
  localparam int unsigned PCT_W      = 7;
  localparam int unsigned QSTEPS     = PCT_W;
  localparam int unsigned TRIAL_W    = SUM_W + QSTEPS - 1;
  localparam int unsigned PADDR_W    = 5;

  localparam logic STATUS_DONE    = 1'b0;
  localparam logic STATUS_IGNORED = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_LASTCHK,
    ST_SUM,
    ST_DIVLOAD,
    ST_DIVRUN
  } state_e;

  typedef struct packed {
    logic             load;
    logic [NUM_W-1:0] num;
    logic [SUM_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [PCT_W-1:0] quot;
  } div_rsp_t;

endpackage

// ===== sv/bucket_histogram_percent.sv =====
// ---------------------------------------------------------------------------
// bucket_histogram_percent
// Bucketed sample histogram; reports every count and its percent share, or a single ignored result for a zero sample.
// ---------------------------------------------------------------------------
// Channel   Direction  Handshake                  Payload
// config    in/out     psel/penable/pwrite/pready paddr, pwdata, prdata
// sample    in         start && !busy             sample_i
// result    out        result_valid_o (1 cycle)   bucket_index_o, bucket_count_o,
//                                                 percent_o, last_o, status_o
//
// A zero sample gives its one result the next cycle; busy stays low.
// Other samples: a search over up to NUM_BUCKETS-1 limits, one last-bucket check,
// a sum of all NUM_BUCKETS counts, then a load and a run per bucket on the
// shared divider, all while busy is high.
// Reset clears all counts and limits; results cannot be stalled.
`include "assert_macros.svh"

module bucket_histogram_percent import bhp_pkg::*; #(
  parameter int unsigned NUM_BUCKETS = 8
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0]  pwdata,
  output logic [DATA_W-1:0]  prdata,
  output logic               pready,
  input  logic               start,
  output logic               busy,
  input  logic [DATA_W-1:0]  sample_i,
  output logic               result_valid_o,
  output logic [2:0]         bucket_index_o,
  output logic [DATA_W-1:0]  bucket_count_o,
  output logic [PCT_W-1:0]   percent_o,
  output logic               last_o,
  output logic               status_o
);

  localparam int unsigned IDX_W = $clog2(NUM_BUCKETS);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_BUCKETS - 1);
  localparam logic [IDX_W-1:0] LAST_SEARCH = IDX_W'(NUM_BUCKETS - 2);
  localparam logic [LIM_IDX_W-1:0] LAST_LIM = LIM_IDX_W'(NUM_BUCKETS - 1);

  state_e             state_q, state_d;
  logic [IDX_W-1:0]   idx_q, idx_d;
  logic [SUM_W-1:0]   total_q, total_d;
  logic [DATA_W-1:0]  sample_q;
  logic [DATA_W-1:0]  cnt_q, cnt_d;
  logic [DATA_W-1:0]  limit_q [LIMIT_REGS];
  logic [DATA_W-1:0]  counts_q [NUM_BUCKETS];
  logic               bump_en;
  logic [IDX_W-1:0]   bump_idx;
  logic               accept;
  logic               cfg_wr;
  logic [DATA_W-1:0]  cur_cnt;
  logic [NUM_W-1:0]   cur_ext;

  logic               out_valid_q, out_valid_d;
  logic [2:0]         out_idx_q, out_idx_d;
  logic [DATA_W-1:0]  out_cnt_q, out_cnt_d;
  logic [PCT_W-1:0]   out_pct_q, out_pct_d;
  logic               out_last_q, out_last_d;
  logic               out_status_q, out_status_d;

  div_req_t div_req;
  div_rsp_t div_rsp;

  bhp_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  assign busy    = (state_q != ST_IDLE);
  assign accept  = start && !busy;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign pready  = 1'b1;
  assign prdata  = limit_q[paddr[PADDR_W-1:2]];
  assign cur_cnt = counts_q[idx_q];
  assign cur_ext = NUM_W'(cur_cnt);

  always_comb begin
    state_d      = state_q;
    idx_d        = idx_q;
    total_d      = total_q;
    cnt_d        = cnt_q;
    bump_en      = 1'b0;
    bump_idx     = idx_q;
    div_req.load = 1'b0;
    div_req.num  = (cur_ext << 6) + (cur_ext << 5) + (cur_ext << 2);
    div_req.den  = total_q;
    out_valid_d  = 1'b0;
    out_idx_d    = out_idx_q;
    out_cnt_d    = out_cnt_q;
    out_pct_d    = out_pct_q;
    out_last_d   = out_last_q;
    out_status_d = out_status_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (sample_i == '0) begin
            out_valid_d  = 1'b1;
            out_idx_d    = '0;
            out_cnt_d    = '0;
            out_pct_d    = '0;
            out_last_d   = 1'b1;
            out_status_d = STATUS_IGNORED;
          end else begin
            state_d = ST_SEARCH;
            idx_d   = '0;
          end
        end
      end
      ST_SEARCH: begin
        if (sample_q < limit_q[LIM_IDX_W'(idx_q)]) begin
          bump_en = 1'b1;
          state_d = ST_LASTCHK;
        end else if (idx_q == LAST_SEARCH) begin
          state_d = ST_LASTCHK;
        end else begin
          idx_d = idx_q + 1'b1;
        end
      end
      ST_LASTCHK: begin
        bump_idx = LAST_IDX;
        bump_en  = (sample_q >= limit_q[LAST_LIM]);
        idx_d    = '0;
        total_d  = '0;
        state_d  = ST_SUM;
      end
      ST_SUM: begin
        total_d = total_q + SUM_W'(cur_cnt);
        if (idx_q == LAST_IDX) begin
          idx_d   = '0;
          state_d = ST_DIVLOAD;
        end else begin
          idx_d = idx_q + 1'b1;
        end
      end
      ST_DIVLOAD: begin
        div_req.load = 1'b1;
        cnt_d        = cur_cnt;
        state_d      = ST_DIVRUN;
      end
      ST_DIVRUN: begin
        if (div_rsp.done) begin
          out_valid_d  = 1'b1;
          out_idx_d    = 3'(idx_q);
          out_cnt_d    = cnt_q;
          out_pct_d    = (total_q == '0) ? '0 : div_rsp.quot;
          out_last_d   = (idx_q == LAST_IDX);
          out_status_d = STATUS_DONE;
          if (idx_q == LAST_IDX) begin
            state_d = ST_IDLE;
          end else begin
            idx_d   = idx_q + 1'b1;
            state_d = ST_DIVLOAD;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < LIMIT_REGS; i++) begin
        limit_q[i] <= '0;
      end
      for (int i = 0; i < NUM_BUCKETS; i++) begin
        counts_q[i] <= '0;
      end
    end else begin
      state_q     <= state_d;
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
      if (cfg_wr) begin
        limit_q[paddr[PADDR_W-1:2]] <= pwdata;
      end
      if (bump_en && (counts_q[bump_idx] != '1)) begin
        counts_q[bump_idx] <= counts_q[bump_idx] + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      sample_q <= sample_i;
    end
    total_q      <= total_d;
    cnt_q        <= cnt_d;
    out_idx_q    <= out_idx_d;
    out_cnt_q    <= out_cnt_d;
    out_pct_q    <= out_pct_d;
    out_last_q   <= out_last_d;
    out_status_q <= out_status_d;
  end

  assign result_valid_o = out_valid_q;
  assign bucket_index_o = out_idx_q;
  assign bucket_count_o = out_cnt_q;
  assign percent_o      = out_pct_q;
  assign last_o         = out_last_q;
  assign status_o       = out_status_q;

  `ASSERT_AT(a_last_frees, clk_i, rst_ni,
             result_valid_o && last_o |-> !busy, "busy after final result")
  `ASSERT_AT(a_ignored_form, clk_i, rst_ni,
             result_valid_o && status_o |-> last_o && bucket_count_o == '0 && percent_o == '0,
             "malformed ignored result")
  `ASSERT_NEVER(a_pct_range, clk_i, rst_ni,
                result_valid_o && percent_o > PCT_W'(100), "percent above 100")
  `ASSERT_AT(a_div_in_run, clk_i, rst_ni,
             div_rsp.done |-> state_q == ST_DIVRUN, "divider done outside run state")

endmodule

// ===== sv/bhp_div.sv =====
// ---------------------------------------------------------------------------
// bhp_div
// Restoring divider, one quotient bit per cycle, 7-bit quotient.
// ---------------------------------------------------------------------------
module bhp_div import bhp_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  div_req_t req_i,
  output div_rsp_t rsp_o
);

  logic [NUM_W-1:0]   rem_q, rem_d;
  logic [SUM_W-1:0]   den_q, den_d;
  logic [PCT_W-1:0]   quot_q, quot_d;
  logic [2:0]         k_q, k_d;
  logic               active_q, active_d;
  logic               done_q, done_d;
  logic [TRIAL_W-1:0] trial;
  logic               fits;

  assign trial = TRIAL_W'(den_q) << k_q;
  assign fits  = TRIAL_W'(rem_q) >= trial;

  always_comb begin
    rem_d    = rem_q;
    den_d    = den_q;
    quot_d   = quot_q;
    k_d      = k_q;
    active_d = active_q;
    done_d   = 1'b0;
    if (req_i.load) begin
      rem_d    = req_i.num;
      den_d    = req_i.den;
      quot_d   = '0;
      k_d      = 3'(QSTEPS - 1);
      active_d = 1'b1;
    end else if (active_q) begin
      if (fits) begin
        rem_d       = rem_q - NUM_W'(trial);
        quot_d[k_q] = 1'b1;
      end
      if (k_q == 3'd0) begin
        active_d = 1'b0;
        done_d   = 1'b1;
      end else begin
        k_d = k_q - 3'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      done_q   <= 1'b0;
      k_q      <= '0;
    end else begin
      active_q <= active_d;
      done_q   <= done_d;
      k_q      <= k_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    den_q  <= den_d;
    quot_q <= quot_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quot = quot_q;

endmodule
